>>> rtl/line_framing_ring_buffer_unit_macros.svh
`ifndef LINE_FRAMING_RING_BUFFER_UNIT_MACROS_SVH
`define LINE_FRAMING_RING_BUFFER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LFRB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfrb assertion failed");

// Next-cycle implication, held off during reset.
`define LFRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfrb assertion failed");

`endif

>>> rtl/lfrb_pkg.sv
package lfrb_pkg;

   localparam int DEPTH       = 64;
   localparam int MAX_TERM    = 4;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int FILL_W      = $clog2(DEPTH);
   localparam int FILL_MAX    = DEPTH - 1;
   localparam int TERM_N      = (MAX_TERM < 4) ? MAX_TERM : 4;
   localparam int TERM_LEN_W  = 3;
   localparam int TIMEOUT_W   = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CMDQ_DEPTH  = 2;
   localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
   localparam int OQ_DEPTH    = 4;
   localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 2);

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] KIND_DROP  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_TERM_BYTES   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TERM_LENGTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_TICK,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } cmd_word_type;

   typedef struct packed {
      logic         we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_write_type;

endpackage

>>> rtl/lfrb_ram.sv
module lfrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lfrb_front.sv
module lfrb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lfrb_pkg::req_word_type req_word,
   output logic                  full,
   output logic                  cmd_valid,
   output lfrb_pkg::cmd_word_type cmd_word,
   input  logic                  cmd_take
);

   lfrb_pkg::cmd_word_type q_ff [lfrb_pkg::CMDQ_DEPTH];
   logic [lfrb_pkg::CMDQ_PTR_W-1:0] wr_ff, wr_in;
   logic [lfrb_pkg::CMDQ_PTR_W-1:0] rd_ff, rd_in;
   logic [lfrb_pkg::CMDQ_CNT_W-1:0] cnt_ff, cnt_in;
   lfrb_pkg::cmd_word_type cls_word;
   logic                   cls_keep;
   logic                   enq;
   logic                   deq;

   always_comb begin
      cls_word.data = req_word.data_byte;
      cls_word.op   = lfrb_pkg::OP_WRITE;
      cls_keep      = 1'b1;
      unique case (req_word.command)
         lfrb_pkg::CMD_WRITE: cls_word.op = lfrb_pkg::OP_WRITE;
         lfrb_pkg::CMD_TICK:  cls_word.op = lfrb_pkg::OP_TICK;
         lfrb_pkg::CMD_CLEAR: cls_word.op = lfrb_pkg::OP_CLEAR;
         default:             cls_keep    = 1'b0;
      endcase
   end

   assign full      = (cnt_ff == lfrb_pkg::CMDQ_CNT_W'(lfrb_pkg::CMDQ_DEPTH));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd_word  = q_ff[rd_ff];
   assign enq       = push && !full && cls_keep;
   assign deq       = cmd_take && cmd_valid;

   always_comb begin
      wr_in  = enq ? wr_ff + 1'b1 : wr_ff;
      rd_in  = deq ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + lfrb_pkg::CMDQ_CNT_W'(enq) - lfrb_pkg::CMDQ_CNT_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (enq) begin
         q_ff[wr_ff] <= cls_word;
      end
   end

endmodule

>>> rtl/lfrb_back.sv
`include "line_framing_ring_buffer_unit_macros.svh"

module lfrb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lfrb_pkg::csr_write_type csr,
   input  logic                   cmd_valid,
   input  lfrb_pkg::cmd_word_type cmd_word,
   output logic                   cmd_take,
   output logic                   empty,
   output lfrb_pkg::rsp_word_type rsp_word,
   input  logic                   pop
);

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic [lfrb_pkg::PTR_W-1:0]      wp_ff, wp_in;
   logic [lfrb_pkg::PTR_W-1:0]      rp_ff, rp_in;
   logic [lfrb_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [lfrb_pkg::FILL_W-1:0]     remain_ff, remain_in;
   logic [lfrb_pkg::TIMEOUT_W-1:0]  idle_ff, idle_in;
   logic [1:0]                      kind_ff, kind_in;
   logic                            rd_pend_ff, rd_pend_in;
   logic [1:0]                      rd_kind_ff, rd_kind_in;
   logic                            rd_last_ff, rd_last_in;
   logic [7:0]                      hist_ff [lfrb_pkg::TERM_N];
   logic [7:0]                      hist_in [lfrb_pkg::TERM_N];
   logic [lfrb_pkg::CSR_DATA_W-1:0] term_ff;
   logic [lfrb_pkg::TERM_LEN_W-1:0] term_len_ff;
   logic [lfrb_pkg::TIMEOUT_W-1:0]  timeout_ff;

   lfrb_pkg::rsp_word_type          oq_ff [lfrb_pkg::OQ_DEPTH];
   logic [lfrb_pkg::OQ_PTR_W-1:0]   oq_wr_ff, oq_wr_in;
   logic [lfrb_pkg::OQ_PTR_W-1:0]   oq_rd_ff, oq_rd_in;
   logic [lfrb_pkg::OQ_CNT_W-1:0]   oq_cnt_ff, oq_cnt_in;
   logic [lfrb_pkg::OQ_CNT_W-1:0]   oq_used;
   logic                            oq_push;
   logic                            oq_pop;
   lfrb_pkg::rsp_word_type          oq_word;

   logic                            can_exec;
   logic                            ram_we;
   logic [7:0]                      ram_rdata;
   logic [lfrb_pkg::TERM_LEN_W-1:0] k_eff;
   logic [lfrb_pkg::FILL_W-1:0]     fill_inc;
   logic [lfrb_pkg::TIMEOUT_W-1:0]  idle_inc;
   logic                            match;
   logic                            drain_issue;
   logic                            drain_done;

   function automatic logic [lfrb_pkg::PTR_W-1:0] next_ptr(
      input logic [lfrb_pkg::PTR_W-1:0] ptr
   );
      logic [lfrb_pkg::PTR_W-1:0] nxt;
      if (ptr == lfrb_pkg::PTR_W'(lfrb_pkg::DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = ptr + 1'b1;
      end
      return nxt;
   endfunction

   lfrb_ram #(
      .WIDTH (8),
      .DEPTH (lfrb_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (cmd_word.data),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   assign k_eff    = (term_len_ff > lfrb_pkg::TERM_LEN_W'(lfrb_pkg::TERM_N))
                     ? lfrb_pkg::TERM_LEN_W'(lfrb_pkg::TERM_N) : term_len_ff;
   assign fill_inc = fill_ff + 1'b1;
   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   assign oq_used  = oq_cnt_ff + lfrb_pkg::OQ_CNT_W'(rd_pend_ff);
   assign oq_pop   = pop && (oq_cnt_ff != '0);
   assign empty    = (oq_cnt_ff == '0);
   assign rsp_word = oq_ff[oq_rd_ff];

   assign can_exec = (state_ff == ST_IDLE) && cmd_valid && !rd_pend_ff
                     && (oq_cnt_ff < lfrb_pkg::OQ_CNT_W'(lfrb_pkg::OQ_DEPTH));
   assign cmd_take = can_exec;
   assign ram_we   = can_exec && (cmd_word.op == lfrb_pkg::OP_WRITE)
                     && (fill_ff != lfrb_pkg::FILL_W'(lfrb_pkg::FILL_MAX));

   assign drain_issue = (state_ff == ST_DRAIN)
                        && (oq_used < lfrb_pkg::OQ_CNT_W'(lfrb_pkg::OQ_DEPTH));
   assign drain_done  = drain_issue && (remain_ff == lfrb_pkg::FILL_W'(1));

   always_comb begin
      hist_in[0] = cmd_word.data;
      for (int j = 1; j < lfrb_pkg::TERM_N; j++) begin
         hist_in[j] = hist_ff[j-1];
      end
   end

   always_comb begin
      logic [lfrb_pkg::TERM_LEN_W-1:0] idx;
      idx   = '0;
      match = (k_eff != '0) && (fill_inc >= lfrb_pkg::FILL_W'(k_eff));
      for (int j = 0; j < lfrb_pkg::TERM_N; j++) begin
         if (lfrb_pkg::TERM_LEN_W'(j) < k_eff) begin
            idx = k_eff - lfrb_pkg::TERM_LEN_W'(j) - 1'b1;
            if (hist_in[j] != term_ff[{idx[1:0], 3'b000} +: 8]) begin
               match = 1'b0;
            end
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      rp_in      = rp_ff;
      fill_in    = fill_ff;
      remain_in  = remain_ff;
      idle_in    = idle_ff;
      kind_in    = kind_ff;
      rd_pend_in = 1'b0;
      rd_kind_in = rd_kind_ff;
      rd_last_in = rd_last_ff;
      oq_push    = 1'b0;
      oq_word    = '{kind: lfrb_pkg::KIND_DROP, out_byte: 8'd0, last: 1'b1};

      if (rd_pend_ff) begin
         oq_push = 1'b1;
         oq_word = '{kind: rd_kind_ff, out_byte: ram_rdata, last: rd_last_ff};
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (can_exec) begin
               unique case (cmd_word.op)
                  lfrb_pkg::OP_WRITE: begin
                     if (!ram_we) begin
                        oq_push = 1'b1;
                     end else begin
                        wp_in   = next_ptr(wp_ff);
                        fill_in = fill_inc;
                        idle_in = '0;
                        if (match) begin
                           state_in  = ST_DRAIN;
                           remain_in = fill_inc;
                           kind_in   = lfrb_pkg::KIND_LINE;
                        end
                     end
                  end
                  lfrb_pkg::OP_TICK: begin
                     idle_in = idle_inc;
                     if ((idle_inc >= timeout_ff) && (fill_ff != '0)) begin
                        state_in  = ST_DRAIN;
                        remain_in = fill_ff;
                        kind_in   = lfrb_pkg::KIND_FLUSH;
                     end
                  end
                  lfrb_pkg::OP_CLEAR: begin
                     wp_in   = '0;
                     rp_in   = '0;
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DRAIN: begin
            if (drain_issue) begin
               rp_in      = next_ptr(rp_ff);
               remain_in  = remain_ff - 1'b1;
               rd_pend_in = 1'b1;
               rd_kind_in = kind_ff;
               rd_last_in = drain_done;
               if (drain_done) begin
                  state_in = ST_IDLE;
                  fill_in  = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      oq_wr_in  = oq_push ? oq_wr_ff + 1'b1 : oq_wr_ff;
      oq_rd_in  = oq_pop ? oq_rd_ff + 1'b1 : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + lfrb_pkg::OQ_CNT_W'(oq_push) - lfrb_pkg::OQ_CNT_W'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         rp_ff       <= '0;
         fill_ff     <= '0;
         remain_ff   <= '0;
         idle_ff     <= '0;
         kind_ff     <= lfrb_pkg::KIND_LINE;
         rd_pend_ff  <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_cnt_ff   <= '0;
         term_ff     <= lfrb_pkg::CSR_DATA_W'(10);
         term_len_ff <= lfrb_pkg::TERM_LEN_W'(1);
         timeout_ff  <= lfrb_pkg::TIMEOUT_W'(100);
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         fill_ff    <= fill_in;
         remain_ff  <= remain_in;
         idle_ff    <= idle_in;
         kind_ff    <= kind_in;
         rd_pend_ff <= rd_pend_in;
         oq_wr_ff   <= oq_wr_in;
         oq_rd_ff   <= oq_rd_in;
         oq_cnt_ff  <= oq_cnt_in;
         if (csr.we) begin
            unique case (csr.index)
               lfrb_pkg::REG_TERM_BYTES:   term_ff     <= csr.wdata;
               lfrb_pkg::REG_TERM_LENGTH:  term_len_ff <= csr.wdata[lfrb_pkg::TERM_LEN_W-1:0];
               lfrb_pkg::REG_IDLE_TIMEOUT: timeout_ff  <= csr.wdata[lfrb_pkg::TIMEOUT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      rd_kind_ff <= rd_kind_in;
      rd_last_ff <= rd_last_in;
      if (ram_we) begin
         hist_ff <= hist_in;
      end
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_word;
      end
   end

   `LFRB_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= lfrb_pkg::FILL_W'(lfrb_pkg::FILL_MAX))
   `LFRB_ASSERT_IMPLY(a_oq_no_overflow, clock, reset, oq_push,
      (oq_cnt_ff < lfrb_pkg::OQ_CNT_W'(lfrb_pkg::OQ_DEPTH)) || oq_pop)
   `LFRB_ASSERT_IMPLY(a_drain_nonzero, clock, reset, state_ff == ST_DRAIN,
      remain_ff != '0)
   `LFRB_ASSERT_NEXT(a_drain_ends_empty, clock, reset, drain_done,
      rd_pend_ff && rd_last_ff && (fill_ff == '0) && (rp_ff == wp_ff))

endmodule

>>> rtl/line_framing_ring_buffer_unit.sv
// Line framing ring buffer: words pushed in carry a command (write a byte, a one
// millisecond tick, or clear) and bytes are kept in a 64-entry ring, of which 63 are
// usable. When the newest bytes match the configured terminator, the whole line is
// popped out as line bytes with last set on the final one; a tick that leaves the idle
// count at or above the timeout flushes any held bytes the same way, and a write into a
// full ring returns a single dropped word. A command word is taken from the input queue
// and executed in the cycle it is taken. A line or flush then holds the executing side
// while its bytes are read out, one byte a cycle through the single read port of the
// byte store while the result queue has room, and until the last byte has left it.
// The two-entry command queue keeps accepting during that until both entries are taken.
module line_framing_ring_buffer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  lfrb_pkg::req_word_type               req_word,
   output logic                                 full,
   output logic                                 empty,
   output lfrb_pkg::rsp_word_type               rsp_word,
   input  logic                                 pop,
   input  logic                                 csr_write_enable,
   input  logic [lfrb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [lfrb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lfrb_pkg::cmd_word_type  cmd_word;
   lfrb_pkg::csr_write_type csr;
   logic                    cmd_valid;
   logic                    cmd_take;

   assign csr = '{we: csr_write_enable, index: csr_index, wdata: csr_wdata};

   lfrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_word  (req_word),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_take  (cmd_take)
   );

   lfrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (cmd_valid),
      .cmd_word  (cmd_word),
      .cmd_take  (cmd_take),
      .empty     (empty),
      .rsp_word  (rsp_word),
      .pop       (pop)
   );

endmodule
